// ===== rtl/xsr_pkg.sv =====
// shared types and constants for the xorshift1024* bounded generator
`default_nettype none
package xsr_pkg;
   localparam logic [63:0] SCRAMBLE_MULT = 64'd1181783497276652981;
   localparam int SHIFT_A = 31;
   localparam int SHIFT_B = 11;
   localparam int SHIFT_C = 30;
   localparam logic ACTION_SEED = 1'b0;
   localparam logic ACTION_DRAW = 1'b1;

   // request from the sequencer to the ring unit
   typedef struct packed {
      logic seed;
      logic step;
      logic [3:0] index;
      logic [63:0] word;
   } ring_cmd_type;

   // ring unit reply
   typedef struct packed {
      logic done;
      logic [63:0] raw;
   } ring_rsp_type;
endpackage
`default_nettype wire

// ===== rtl/xsr_ring.sv =====
// state ring memory and generator step (read, modify, write back)
`default_nettype none
module xsr_ring #(
   parameter int STATE_WORDS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire xsr_pkg::ring_cmd_type cmd,
   output xsr_pkg::ring_rsp_type rsp
);
   import xsr_pkg::*;
   localparam int PW = $clog2(STATE_WORDS);

   typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_MIX, S_MUL0, S_MUL1, S_MUL2} st_type;

   logic [63:0] ring_mem [STATE_WORDS];
   logic [STATE_WORDS-1:0] valid_ff;
   logic [63:0] rd_data;
   logic [PW-1:0] rd_addr;
   logic [PW-1:0] ptr_ff;
   logic [PW-1:0] ptr_in;
   logic [63:0] s0_ff, s1_ff, mix_ff, raw_ff;
   logic [63:0] pm0_ff, pm1_ff;
   logic [63:0] s1x, s_new;
   logic rd_valid_ff;
   logic done_ff;
   st_type st_ff;

   assign ptr_in = ptr_ff + PW'(1);
   assign rd_addr = (st_ff == S_IDLE) ? ptr_ff : ptr_in;

   // unwritten entries read as zero through the valid bits
   always_ff @(posedge clock) begin
      rd_data <= ring_mem[rd_addr];
      if (cmd.seed) ring_mem[cmd.index[PW-1:0]] <= cmd.word;
      else if (st_ff == S_MIX) ring_mem[ptr_ff] <= s_new;
   end

   assign s1x = s1_ff ^ (s1_ff << SHIFT_A);
   assign s_new = s1x ^ s0_ff ^ (s1x >> SHIFT_B) ^ (s0_ff >> SHIFT_C);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff <= '0;
         st_ff <= S_IDLE;
         done_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         rd_valid_ff <= valid_ff[rd_addr];
         if (cmd.seed) valid_ff[cmd.index[PW-1:0]] <= 1'b1;
         case (st_ff)
            S_IDLE: if (cmd.step) st_ff <= S_RD1;
            S_RD1: begin
               s0_ff <= rd_valid_ff ? rd_data : 64'd0;
               st_ff <= S_RD2;
            end
            S_RD2: begin
               s1_ff <= rd_valid_ff ? rd_data : 64'd0;
               ptr_ff <= ptr_in;
               st_ff <= S_MIX;
            end
            S_MIX: begin
               mix_ff <= s_new;
               valid_ff[ptr_ff] <= 1'b1;
               st_ff <= S_MUL0;
            end
            // scrambling multiply mod 2^64 from 32-bit partial products
            S_MUL0: begin
               pm0_ff <= mix_ff[31:0] * SCRAMBLE_MULT[31:0];
               st_ff <= S_MUL1;
            end
            S_MUL1: begin
               pm1_ff <= {mix_ff[63:32] * SCRAMBLE_MULT[31:0], 32'd0};
               st_ff <= S_MUL2;
            end
            S_MUL2: begin
               raw_ff <= pm0_ff + pm1_ff + {mix_ff[31:0] * SCRAMBLE_MULT[63:32], 32'd0};
               done_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.raw = raw_ff;
endmodule
`default_nettype wire

// ===== rtl/xsr_div.sv =====
// 64-bit restoring divider, one quotient bit per cycle
`default_nettype none
module xsr_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic go,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic done,
   output logic [63:0] quo
);
   logic [63:0] q_ff, r_ff, d_ff;
   logic [64:0] trial;
   logic [6:0] cnt_ff;
   logic busy_ff, done_ff;

   assign trial = {r_ff, q_ff[63]} - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            q_ff <= num;
            r_ff <= '0;
            d_ff <= den;
            cnt_ff <= 7'd64;
         end else if (busy_ff) begin
            // quotient bits shift in where the numerator shifts out
            if (!trial[64]) begin
               r_ff <= trial[63:0];
               q_ff <= {q_ff[62:0], 1'b1};
            end else begin
               r_ff <= {r_ff[62:0], q_ff[63]};
               q_ff <= {q_ff[62:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo = q_ff;
endmodule
`default_nettype wire

// ===== rtl/xorshift1024star_bounded_rng_unit.sv =====
// top level: command sequencer for seed loads and bounded draws
// A seed load writes its ring word at the accepting clock edge and holds busy through T_SEED.
// An unbounded draw (bound zero) gives its result after the ring read, read, mix and write
// back, a split multiply, capture and check. A bounded draw first divides all-ones by the
// bound for the bucket, forms the limit with a 32x32-split multiply, then runs the generator
// step, repeated for each rejected raw value, and last divides raw by bucket.
// Results come as a one-cycle rsp_valid strobe that the receiver cannot stall; busy is
// high from the accepted start until the result.
`default_nettype none
module xorshift1024star_bounded_rng_unit #(
   parameter int STATE_WORDS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic req_action,
   input  wire logic [3:0] req_seed_index,
   input  wire logic [63:0] req_seed_word,
   input  wire logic [63:0] req_bound,
   output logic rsp_valid,
   output logic [63:0] rsp_value
);
   import xsr_pkg::*;

   typedef enum logic [3:0] {
      T_IDLE, T_SEED, T_BKT, T_BKTW, T_LIM0, T_LIM1, T_LIM2, T_GEN, T_GENW, T_CHK,
      T_QDIV, T_QDIVW
   } st_type;

   st_type st_ff;
   logic busy_ff, valid_ff;
   logic [63:0] value_ff, bound_ff, bucket_ff, limit_ff, raw_ff;
   logic [63:0] p0_ff, p1_ff;
   ring_cmd_type cmd;
   ring_rsp_type rr;
   logic div_go;
   logic [63:0] div_num, div_den, div_q;
   logic div_done;
   logic accept;

   assign accept = start && !busy_ff;

   assign cmd.seed = accept && (req_action == ACTION_SEED);
   assign cmd.index = req_seed_index;
   assign cmd.word = req_seed_word;
   assign cmd.step = (st_ff == T_GEN);

   xsr_ring #(.STATE_WORDS(STATE_WORDS)) u_ring (
      .clock(clock), .reset(reset), .cmd(cmd), .rsp(rr)
   );

   assign div_go = (st_ff == T_BKT) || (st_ff == T_QDIV);
   assign div_num = (st_ff == T_BKT) ? 64'hFFFF_FFFF_FFFF_FFFF : raw_ff;
   assign div_den = (st_ff == T_BKT) ? bound_ff : bucket_ff;

   xsr_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .num(div_num), .den(div_den),
      .done(div_done), .quo(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= T_IDLE;
         busy_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (st_ff)
            T_IDLE: if (accept) begin
               busy_ff <= 1'b1;
               bound_ff <= req_bound;
               if (req_action == ACTION_SEED) st_ff <= T_SEED;
               else if (req_bound == 64'd0) st_ff <= T_GEN;
               else st_ff <= T_BKT;
            end
            T_SEED: begin
               busy_ff <= 1'b0;
               st_ff <= T_IDLE;
            end
            T_BKT: st_ff <= T_BKTW;
            T_BKTW: if (div_done) begin
               bucket_ff <= div_q;
               st_ff <= T_LIM0;
            end
            // limit = bucket * bound mod 2^64 from 32-bit partial products
            T_LIM0: begin
               p0_ff <= bucket_ff[31:0] * bound_ff[31:0];
               st_ff <= T_LIM1;
            end
            T_LIM1: begin
               p1_ff <= {bucket_ff[63:32] * bound_ff[31:0], 32'd0};
               st_ff <= T_LIM2;
            end
            T_LIM2: begin
               limit_ff <= p0_ff + p1_ff + {bucket_ff[31:0] * bound_ff[63:32], 32'd0};
               st_ff <= T_GEN;
            end
            T_GEN: st_ff <= T_GENW;
            T_GENW: if (rr.done) begin
               raw_ff <= rr.raw;
               st_ff <= T_CHK;
            end
            T_CHK: begin
               if (bound_ff == 64'd0) begin
                  value_ff <= raw_ff;
                  valid_ff <= 1'b1;
                  busy_ff <= 1'b0;
                  st_ff <= T_IDLE;
               end else if (raw_ff >= limit_ff) st_ff <= T_GEN;
               else st_ff <= T_QDIV;
            end
            T_QDIV: st_ff <= T_QDIVW;
            T_QDIVW: if (div_done) begin
               value_ff <= div_q;
               valid_ff <= 1'b1;
               busy_ff <= 1'b0;
               st_ff <= T_IDLE;
            end
            default: st_ff <= T_IDLE;
         endcase
      end
   end

   assign busy = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;
endmodule
`default_nettype wire

// ===== rtl/xsr_checker.sv =====
// port-level checks for the generator unit
`default_nettype none
module xsr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_action,
   input wire logic rsp_valid
);
   import xsr_pkg::*;

   a_seed_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACTION_SEED) |=> busy ##1 !busy)
      else $error("seed transfer timing");
   a_seed_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACTION_SEED) |=> !rsp_valid ##1 !rsp_valid)
      else $error("seed transfer gave a result");
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACTION_DRAW) |=> busy)
      else $error("draw not busy");
   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result outside a draw");
endmodule
bind xorshift1024star_bounded_rng_unit xsr_checker u_xsr_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_action(req_action), .rsp_valid(rsp_valid)
);
`default_nettype wire
